@@ src/stepper_step_rate_generator_assert.svh @@
// Assertion macros for the stepper step rate generator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef STEPPER_STEP_RATE_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_RATE_GENERATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define SRG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srg assertion failed");

// Check that a condition implies another in the next cycle
`define SRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srg assertion failed");

`endif

@@ src/srg_pkg.sv @@
// Shared types and constants for the stepper step rate generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

  localparam int unsigned CountW    = 13;
  localparam int unsigned MagW      = 16;
  localparam int unsigned MicroW    = 8;
  localparam int unsigned DeadbandW = 15;
  localparam int unsigned ProdW     = 23;
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned DivCntW   = 4;

  localparam logic [CountW-1:0]  CountMax   = 13'd8191;
  // ceil(7200 / p) is (7199 / p) + 1 for any p > 0
  localparam logic [CountW-1:0]  DivNumer   = 13'd7199;
  localparam logic [DivCntW-1:0] DivSteps   = 4'd13;
  localparam logic [MicroW-1:0]  MicroReset = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MICROSTEP = 1'b0,
    REG_DEADBAND  = 1'b1
  } srg_reg_e;

  typedef enum logic {
    REQ_SETTINGS = 1'b0,
    REQ_TICK     = 1'b1
  } srg_req_type_e;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] speed;
    logic               enable;
  } srg_req_t;

  typedef struct packed {
    logic enable_pin;
    logic dir_pin;
    logic step_pin;
    logic step_running;
  } srg_res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic tick;
    logic settle;
    logic run_zero;
    logic div_start;
    logic div_step;
    logic fin;
  } srg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic skip;
    logic prod_zero;
    logic div_last;
  } srg_stat_t;

endpackage

`default_nettype wire

@@ src/srg_ctrl.sv @@
// Sequencer for the stepper step rate generator.
// Depends on srg_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module srg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_stall_o,
  output logic                  res_valid_o,
  input  wire logic             res_stall_i,
  input  wire srg_pkg::srg_stat_t stat_i,
  output srg_pkg::srg_cmd_t     cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } srg_state_e;

  srg_state_e state_q, state_d;

  // Take a request only when no work or result is pending
  assign req_stall_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (stat_i.is_tick) begin
          cmd_o.tick = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.settle = 1'b1;
          state_d      = stat_i.skip ? S_OUT : S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.prod_zero) begin
          cmd_o.run_zero = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/srg_datapath.sv @@
// Datapath for the stepper step rate generator: settings registers, pin
// state, tick counter and a serial period divider. Depends on srg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srg_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [srg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [srg_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire srg_pkg::srg_req_t               req_i,
  input  wire srg_pkg::srg_cmd_t               cmd_i,
  output srg_pkg::srg_stat_t                   stat_o,
  output srg_pkg::srg_res_t                    res_o
);

  // Configuration registers
  logic [srg_pkg::MicroW-1:0]    micro_q;
  logic [srg_pkg::DeadbandW-1:0] deadband_q;

  // Latched request
  logic                       type_q;
  logic                       en_q;
  logic                       neg_q;
  logic [srg_pkg::MagW-1:0]   mag_q;

  // Pin and stepping state
  logic enable_q, enable_d;
  logic dir_q, dir_d;
  logic step_q, step_d;
  logic running_q, running_d;
  logic never_q, never_d;
  logic [srg_pkg::CountW-1:0] period_q, period_d;
  logic [srg_pkg::CountW-1:0] count_q, count_d;

  // Divider
  logic [srg_pkg::ProdW-1:0]   prod_q, prod_d;
  logic [srg_pkg::ProdW-1:0]   rem_q, rem_d;
  logic [srg_pkg::CountW-1:0]  quo_q, quo_d;
  logic [srg_pkg::DivCntW-1:0] dcnt_q, dcnt_d;

  logic [srg_pkg::MagW-1:0]     mag_w;
  logic [2*srg_pkg::MagW-1:0]   prod_full;
  logic                         below;
  logic [srg_pkg::ProdW:0]      trial;
  logic [srg_pkg::ProdW:0]      diff;
  logic                         ge;
  logic [srg_pkg::CountW-1:0]   count_inc;

  // Magnitude of the speed; the most negative value maps to 32768
  assign mag_w = req_i.speed[15] ? (~req_i.speed + 16'd1) : req_i.speed;

  assign prod_full = {16'd0, mag_q} * {24'd0, micro_q};
  assign below     = ({1'b0, mag_q} < {2'b00, deadband_q});

  // One restoring division step per cycle
  assign trial = {rem_q, quo_q[srg_pkg::CountW-1]};
  assign ge    = (trial >= {1'b0, prod_q});
  assign diff  = trial - {1'b0, prod_q};

  // Saturating counter increment
  assign count_inc = (count_q == srg_pkg::CountMax) ? count_q : count_q + 13'd1;

  assign stat_o.is_tick   = (type_q == srg_pkg::REQ_TICK);
  assign stat_o.skip      = !en_q || below;
  assign stat_o.prod_zero = (prod_q == '0);
  assign stat_o.div_last  = (dcnt_q == 4'd1);

  assign res_o.enable_pin   = enable_q;
  assign res_o.dir_pin      = dir_q;
  assign res_o.step_pin     = step_q;
  assign res_o.step_running = running_q;

  // Next values of the state
  always_comb begin
    enable_d  = enable_q;
    dir_d     = dir_q;
    step_d    = step_q;
    running_d = running_q;
    never_d   = never_q;
    period_d  = period_q;
    count_d   = count_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    if (cmd_i.tick && running_q) begin
      if (!never_q && (count_inc >= period_q)) begin
        count_d = '0;
        step_d  = ~step_q;
      end else begin
        count_d = count_inc;
      end
    end
    if (cmd_i.settle) begin
      if (!en_q) begin
        enable_d  = 1'b0;
        running_d = 1'b0;
      end else if (below) begin
        enable_d  = 1'b1;
        running_d = 1'b0;
      end else begin
        enable_d = 1'b1;
        if (neg_q) begin
          dir_d = 1'b0;
        end else if (mag_q != '0) begin
          dir_d = 1'b1;
        end
      end
      prod_d = prod_full[srg_pkg::ProdW-1:0];
    end
    if (cmd_i.run_zero) begin
      never_d   = 1'b1;
      running_d = 1'b1;
    end
    if (cmd_i.div_start) begin
      rem_d  = '0;
      quo_d  = srg_pkg::DivNumer;
      dcnt_d = srg_pkg::DivSteps;
    end
    if (cmd_i.div_step) begin
      rem_d  = ge ? diff[srg_pkg::ProdW-1:0] : trial[srg_pkg::ProdW-1:0];
      quo_d  = {quo_q[srg_pkg::CountW-2:0], ge};
      dcnt_d = dcnt_q - 4'd1;
    end
    if (cmd_i.fin) begin
      period_d  = quo_q + 13'd1;
      never_d   = 1'b0;
      running_d = 1'b1;
    end
  end

  // Hold configuration and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      micro_q    <= srg_pkg::MicroReset;
      deadband_q <= '0;
      enable_q   <= 1'b0;
      dir_q      <= 1'b0;
      step_q     <= 1'b0;
      running_q  <= 1'b0;
      never_q    <= 1'b1;
      period_q   <= '0;
      count_q    <= '0;
      dcnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srg_pkg::REG_MICROSTEP: micro_q    <= cfg_data_i[srg_pkg::MicroW-1:0];
          srg_pkg::REG_DEADBAND:  deadband_q <= cfg_data_i[srg_pkg::DeadbandW-1:0];
          default: begin
          end
        endcase
      end
      enable_q  <= enable_d;
      dir_q     <= dir_d;
      step_q    <= step_d;
      running_q <= running_d;
      never_q   <= never_d;
      period_q  <= period_d;
      count_q   <= count_d;
      dcnt_q    <= dcnt_d;
    end
  end

  // Latch the request and the divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_i.req_type;
      en_q   <= req_i.enable;
      neg_q  <= req_i.speed[15];
      mag_q  <= mag_w;
    end
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

endmodule

`default_nettype wire

@@ src/stepper_step_rate_generator.sv @@
// Step/direction generator for one stepper driver, one request at a time.
// Tick, disable and below-deadband requests go through decode straight to the result.
// Zero-product settings add a check state; other settings also run the 13-step
// serial period divider and a finish state. Next request is taken the cycle after the result is accepted.
// Reset (async, active low): pins low, stepping stopped, microstep 1, deadband 0.
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_step_rate_generator_assert.svh"

module stepper_step_rate_generator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [srg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [srg_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         req_valid_i,
  output logic                              req_stall_o,
  input  wire srg_pkg::srg_req_t            req_i,
  output logic                              res_valid_o,
  input  wire logic                         res_stall_i,
  output srg_pkg::srg_res_t                 res_o
);

  srg_pkg::srg_cmd_t  ctrl_cmd;
  srg_pkg::srg_stat_t dp_stat;

  // Sequence each request
  srg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  // Hold pin state and compute the step period
  srg_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (ctrl_cmd),
    .stat_o     (dp_stat),
    .res_o      (res_o)
  );

  // Commands never overlap
  `SRG_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(ctrl_cmd))
  // A pending result blocks new requests
  `SRG_ASSERT_SAME(a_res_blocks_req, res_valid_o, req_stall_o)
  // An accepted request is not answered in the same cycle it lands
  `SRG_ASSERT_NEXT(a_accept_busy, req_valid_i && !req_stall_o, req_stall_o && !res_valid_o)
  // Finishing the divide presents the result next
  `SRG_ASSERT_NEXT(a_fin_result, ctrl_cmd.fin, res_valid_o && res_o.step_running)

endmodule

`default_nettype wire
